/* rtl/core/qmcu_pkg.sv */
// Shared types and constants for the queued mutex and condition unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package qmcu_pkg;

    localparam int THREADS_DEF = 16;
    localparam int MODE_W      = 3;
    localparam int TID_W       = 4;
    localparam int STATUS_W    = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_MUTEX_INIT  = 3'd0,
        MODE_LOCK        = 3'd1,
        MODE_UNLOCK      = 3'd2,
        MODE_COND_INIT   = 3'd3,
        MODE_COND_WAIT   = 3'd4,
        MODE_COND_SIGNAL = 3'd5
    } qmcu_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_NOT_INIT  = 3'd2,
        ST_OWNERSHIP = 3'd3,
        ST_FULL      = 3'd4
    } qmcu_status_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_READ,
        CTRL_EXEC
    } qmcu_state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;   // capture the incoming item
        logic read;    // register both queue heads
        logic exec;    // apply the operation and load the result register
    } qmcu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_stall;  // result register still holds an untaken item
    } qmcu_stat_t;

endpackage

`default_nettype wire

/* rtl/core/qmcu_ctrl.sv */
// Sequencer for the queued mutex and condition unit.
// Depends on qmcu_pkg; drives qmcu_dpath through qmcu_cmd_t.
`default_nettype none

module qmcu_ctrl
    import qmcu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire qmcu_stat_t stat,
    output qmcu_cmd_t       cmd
);

    qmcu_state_t state_reg;
    qmcu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            CTRL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = CTRL_READ;
                end
            end
            CTRL_READ:
            begin
                cmd.read   = 1'b1;
                state_next = CTRL_EXEC;
            end
            CTRL_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    cmd.exec   = 1'b1;
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/qmcu_dpath.sv */
// Datapath: mutex/condition state, two circular wait queues in memory, result register.
// Depends on qmcu_pkg; sequenced by qmcu_ctrl.
`default_nettype none

module qmcu_dpath
    import qmcu_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire qmcu_cmd_t           cmd,
    output qmcu_stat_t               stat,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [TID_W-1:0]    thread,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic                     caller_blocks,
    output logic                     woken_valid,
    output logic [TID_W-1:0]         woken_thread
);

    localparam int CNT_W = $clog2(THREADS + 1);
    localparam int PTR_W = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(THREADS);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(THREADS - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // request
    logic [MODE_W-1:0] mode_reg;
    logic [TID_W-1:0]  thread_reg;

    // lock state
    logic              mutex_ready_reg, mutex_ready_next;
    logic              owner_present_reg, owner_present_next;
    logic [TID_W-1:0]  owner_reg, owner_next;
    logic              cond_ready_reg, cond_ready_next;

    // queues
    logic [TID_W-1:0]  lock_mem [THREADS];
    logic [TID_W-1:0]  cond_mem [THREADS];
    logic [TID_W-1:0]  lock_head_data_reg;
    logic [TID_W-1:0]  cond_head_data_reg;
    logic [PTR_W-1:0]  lock_head_reg, lock_head_next, lock_tail_reg, lock_tail_next;
    logic [PTR_W-1:0]  cond_head_reg, cond_head_next, cond_tail_reg, cond_tail_next;
    logic [CNT_W-1:0]  lock_cnt_reg, lock_cnt_next;
    logic [CNT_W-1:0]  cond_cnt_reg, cond_cnt_next;
    logic              lock_push, cond_push;

    // result
    logic                out_valid_reg, out_valid_next;
    qmcu_status_t        status_reg, status_next;
    logic                blocks_reg, blocks_next;
    logic                wvalid_reg, wvalid_next;
    logic [TID_W-1:0]    wthread_reg, wthread_next;
    logic                owns;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg   <= mode;
            thread_reg <= thread;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            blocks_reg  <= blocks_next;
            wvalid_reg  <= wvalid_next;
            wthread_reg <= wthread_next;
        end
    end

    // queue memories: one write port, registered head read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && lock_push)
        begin
            lock_mem[lock_tail_reg] <= thread_reg;
        end
        if (cmd.exec && cond_push)
        begin
            cond_mem[cond_tail_reg] <= thread_reg;
        end
        if (cmd.read)
        begin
            lock_head_data_reg <= lock_mem[lock_head_reg];
            cond_head_data_reg <= cond_mem[cond_head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mutex_ready_reg   <= 1'b0;
            owner_present_reg <= 1'b0;
            owner_reg         <= '0;
            cond_ready_reg    <= 1'b0;
            lock_head_reg     <= '0;
            lock_tail_reg     <= '0;
            lock_cnt_reg      <= '0;
            cond_head_reg     <= '0;
            cond_tail_reg     <= '0;
            cond_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                mutex_ready_reg   <= mutex_ready_next;
                owner_present_reg <= owner_present_next;
                owner_reg         <= owner_next;
                cond_ready_reg    <= cond_ready_next;
                lock_head_reg     <= lock_head_next;
                lock_tail_reg     <= lock_tail_next;
                lock_cnt_reg      <= lock_cnt_next;
                cond_head_reg     <= cond_head_next;
                cond_tail_reg     <= cond_tail_next;
                cond_cnt_reg      <= cond_cnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        owns               = owner_present_reg && (owner_reg == thread_reg);
        mutex_ready_next   = mutex_ready_reg;
        owner_present_next = owner_present_reg;
        owner_next         = owner_reg;
        cond_ready_next    = cond_ready_reg;
        lock_head_next     = lock_head_reg;
        lock_tail_next     = lock_tail_reg;
        lock_cnt_next      = lock_cnt_reg;
        cond_head_next     = cond_head_reg;
        cond_tail_next     = cond_tail_reg;
        cond_cnt_next      = cond_cnt_reg;
        lock_push          = 1'b0;
        cond_push          = 1'b0;
        status_next        = ST_OK;
        blocks_next        = 1'b0;
        wvalid_next        = 1'b0;
        wthread_next       = '0;

        case (qmcu_mode_t'(mode_reg))
            MODE_MUTEX_INIT:
            begin
                if (mutex_ready_reg)
                begin
                    status_next = ST_ALREADY;
                end
                else
                begin
                    mutex_ready_next   = 1'b1;
                    owner_present_next = 1'b0;
                    owner_next         = '0;
                    lock_cnt_next      = '0;
                    lock_head_next     = '0;
                    lock_tail_next     = '0;
                end
            end
            MODE_LOCK:
            begin
                if (!mutex_ready_reg)
                begin
                    status_next = ST_NOT_INIT;
                end
                else if (owns)
                begin
                    status_next = ST_OWNERSHIP;
                end
                else if (owner_present_reg)
                begin
                    if (lock_cnt_reg == FULL_CNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        lock_push      = 1'b1;
                        blocks_next    = 1'b1;
                        lock_tail_next = ptr_inc(lock_tail_reg);
                        lock_cnt_next  = lock_cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    owner_present_next = 1'b1;
                    owner_next         = thread_reg;
                end
            end
            MODE_UNLOCK:
            begin
                if (!mutex_ready_reg)
                begin
                    status_next = ST_NOT_INIT;
                end
                else if (!owns)
                begin
                    status_next = ST_OWNERSHIP;
                end
                else if (lock_cnt_reg != '0)
                begin
                    // hand the mutex straight to the oldest waiter
                    owner_next     = lock_head_data_reg;
                    wvalid_next    = 1'b1;
                    wthread_next   = lock_head_data_reg;
                    lock_head_next = ptr_inc(lock_head_reg);
                    lock_cnt_next  = lock_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    owner_present_next = 1'b0;
                    owner_next         = '0;
                end
            end
            MODE_COND_INIT:
            begin
                if (cond_ready_reg)
                begin
                    status_next = ST_ALREADY;
                end
                else
                begin
                    cond_ready_next = 1'b1;
                    cond_cnt_next   = '0;
                    cond_head_next  = '0;
                    cond_tail_next  = '0;
                end
            end
            MODE_COND_WAIT:
            begin
                // ownership is checked before the condition is known to be ready
                if (!mutex_ready_reg)
                begin
                    status_next = ST_NOT_INIT;
                end
                else if (!owns)
                begin
                    status_next = ST_OWNERSHIP;
                end
                else if (!cond_ready_reg)
                begin
                    status_next = ST_NOT_INIT;
                end
                else if (cond_cnt_reg == FULL_CNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cond_push      = 1'b1;
                    blocks_next    = 1'b1;
                    cond_tail_next = ptr_inc(cond_tail_reg);
                    cond_cnt_next  = cond_cnt_reg + CNT_W'(1);
                end
            end
            MODE_COND_SIGNAL:
            begin
                if (!cond_ready_reg)
                begin
                    status_next = ST_NOT_INIT;
                end
                else if (cond_cnt_reg != '0)
                begin
                    wvalid_next    = 1'b1;
                    wthread_next   = cond_head_data_reg;
                    cond_head_next = ptr_inc(cond_head_reg);
                    cond_cnt_next  = cond_cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign stat.out_stall = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign caller_blocks  = blocks_reg;
    assign woken_valid    = wvalid_reg;
    assign woken_thread   = wthread_reg;

    a_lock_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        lock_cnt_reg <= FULL_CNT)
        else $error("lock queue count above depth");

    a_cond_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cond_cnt_reg <= FULL_CNT)
        else $error("condition queue count above depth");

    a_block_xor_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && blocks_reg) |-> (!wvalid_reg && status_reg == ST_OK))
        else $error("blocked caller reported with wake or error");

    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && wvalid_reg) |-> (status_reg == ST_OK))
        else $error("wake reported with error status");

    a_owner_after_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && wvalid_next && mode_reg == MODE_UNLOCK)
            |=> (owner_present_reg && owner_reg == wthread_reg))
        else $error("unlock handoff did not install woken thread as owner");

endmodule

`default_nettype wire

/* rtl/core/queued_mutex_and_condition_unit.sv */
// Lock manager for one mutex and one condition variable, each with a FIFO of waiting
// threads. Each request passes through accept, queue-head read from the
// wait-queue memories, then execute into the result register; a new request is accepted
// the cycle after execute. The result register frees the input side while an item waits
// at the output; execute waits only if the previous result is still untaken. The queues
// are circular buffers, so no clearing pass is needed after reset.
`default_nettype none

module queued_mutex_and_condition_unit
    import qmcu_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [TID_W-1:0]    thread,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic                     caller_blocks,
    output logic                     woken_valid,
    output logic [TID_W-1:0]         woken_thread
);

    qmcu_cmd_t  cmd;
    qmcu_stat_t stat;

    qmcu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qmcu_dpath #(
        .THREADS (THREADS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .thread        (thread),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .caller_blocks (caller_blocks),
        .woken_valid   (woken_valid),
        .woken_thread  (woken_thread)
    );

endmodule

`default_nettype wire

/* tb/sv/lock_manager_sb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the queued mutex and condition unit: tracks owner, lock waiters and
// condition waiters, predicts one reply per request and checks replies in order.
// Depends on qmcu_pkg for the mode and status codes.

package lock_manager_sb_pkg;

    import qmcu_pkg::*;

    typedef struct {
        qmcu_status_t   status;
        bit             blocks;
        bit             wvalid;
        bit [TID_W-1:0] wthread;
    } lock_reply_t;

    class lock_manager_scoreboard;

        bit             mutex_ready;
        bit             owner_held;
        bit [TID_W-1:0] owner_id;
        bit [TID_W-1:0] lock_line[$];
        bit             cond_ready;
        bit [TID_W-1:0] cond_line[$];

        lock_reply_t    pending_replies[$];
        int             mismatches;

        function new();
            mutex_ready = 1'b0;
            owner_held  = 1'b0;
            owner_id    = '0;
            cond_ready  = 1'b0;
            mismatches  = 0;
        endfunction

        function lock_reply_t predict_reply(logic [MODE_W-1:0] m, logic [TID_W-1:0] t);
            lock_reply_t r;
            bit          owns;
            r    = '{ST_OK, 1'b0, 1'b0, '0};
            owns = owner_held && (owner_id == t);
            case (m)
                MODE_MUTEX_INIT:
                begin
                    if (mutex_ready)
                        r.status = ST_ALREADY;
                    else
                    begin
                        mutex_ready = 1'b1;
                        owner_held  = 1'b0;
                        owner_id    = '0;
                        lock_line.delete();
                    end
                end
                MODE_LOCK:
                begin
                    if (!mutex_ready)
                        r.status = ST_NOT_INIT;
                    else if (owns)
                        r.status = ST_OWNERSHIP;
                    else if (owner_held)
                    begin
                        if (lock_line.size() < THREADS_DEF)
                        begin
                            lock_line.push_back(t);
                            r.blocks = 1'b1;
                        end
                        else
                            r.status = ST_FULL;
                    end
                    else
                    begin
                        owner_held = 1'b1;
                        owner_id   = t;
                    end
                end
                MODE_UNLOCK:
                begin
                    if (!mutex_ready)
                        r.status = ST_NOT_INIT;
                    else if (!owns)
                        r.status = ST_OWNERSHIP;
                    else if (lock_line.size() > 0)
                    begin
                        // ownership passes straight to the oldest waiter
                        owner_id  = lock_line.pop_front();
                        r.wvalid  = 1'b1;
                        r.wthread = owner_id;
                    end
                    else
                    begin
                        owner_held = 1'b0;
                        owner_id   = '0;
                    end
                end
                MODE_COND_INIT:
                begin
                    if (cond_ready)
                        r.status = ST_ALREADY;
                    else
                    begin
                        cond_ready = 1'b1;
                        cond_line.delete();
                    end
                end
                MODE_COND_WAIT:
                begin
                    // ownership is checked ahead of the condition being ready
                    if (!mutex_ready)
                        r.status = ST_NOT_INIT;
                    else if (!owns)
                        r.status = ST_OWNERSHIP;
                    else if (!cond_ready)
                        r.status = ST_NOT_INIT;
                    else if (cond_line.size() < THREADS_DEF)
                    begin
                        cond_line.push_back(t);
                        r.blocks = 1'b1;
                    end
                    else
                        r.status = ST_FULL;
                end
                MODE_COND_SIGNAL:
                begin
                    if (!cond_ready)
                        r.status = ST_NOT_INIT;
                    else if (cond_line.size() > 0)
                    begin
                        r.wthread = cond_line.pop_front();
                        r.wvalid  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [TID_W-1:0] t);
            pending_replies.push_back(predict_reply(m, t));
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic blk, logic wv,
                                  logic [TID_W-1:0] wt);
            lock_reply_t e;
            bit          bad;
            if (pending_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected reply: status %0d blocks %0b woken %0b/%0d",
                             st, blk, wv, wt);
                mismatches++;
                return;
            end
            e   = pending_replies.pop_front();
            bad = 1'b0;
            if (st !== e.status)
                bad = 1'b1;
            if (blk !== e.blocks)
                bad = 1'b1;
            if (wv !== e.wvalid)
                bad = 1'b1;
            if (wt !== e.wthread)
                bad = 1'b1;
            if (bad)
            begin
                if (mismatches < 10)
                    $display("reply mismatch: exp status %0d blocks %0b woken %0b/%0d",
                             e.status, e.blocks, e.wvalid, e.wthread,
                             ", got status %0d blocks %0b woken %0b/%0d",
                             st, blk, wv, wt);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the testbench for queued_mutex_and_condition_unit: clock, reset, request
// driver, reply sink and run control. Depends on qmcu_pkg and lock_manager_sb_pkg.

module tb_top;

    import qmcu_pkg::*;
    import lock_manager_sb_pkg::*;

    localparam int RANDOM_REQUESTS = 800;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int BURST_LEN       = 18;

    // modes the block does not decode
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [TID_W-1:0]    thread;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic                caller_blocks;
    logic                woken_valid;
    logic [TID_W-1:0]    woken_thread;

    int  send_idle_pct = 16;
    int  recv_idle_pct = 78;
    bit  hold_phase    = 1'b0;
    bit  hold_out      = 1'b0;
    int  cycles        = 0;
    int  burst_left    = 0;
    bit  burst_cond    = 1'b0;

    lock_manager_scoreboard sb;

    always #6 clk = ~clk;

    queued_mutex_and_condition_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .thread        (thread),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .caller_blocks (caller_blocks),
        .woken_valid   (woken_valid),
        .woken_thread  (woken_thread)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL queued_mutex_and_condition_unit");
            $finish;
        end
    end

    // reply sink
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply(status, caller_blocks, woken_valid, woken_thread);
        out_ready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_phase);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [TID_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        thread   <= t;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(m, t);
    endtask

    // mostly legal traffic built from the tracked state, with bursts that fill the queues
    task automatic pick_request(output logic [MODE_W-1:0] m, output logic [TID_W-1:0] t);
        int r;
        t = TID_W'($urandom_range(15));
        m = MODE_LOCK;
        if (burst_left > 0)
        begin
            burst_left--;
            if (burst_cond && sb.owner_held)
            begin
                m = MODE_COND_WAIT;
                t = sb.owner_id;
            end
            return;
        end
        r = $urandom_range(99);
        if (r < 3)
        begin
            burst_left = BURST_LEN;
            burst_cond = 1'($urandom_range(1));
        end
        if (r < 28)
            m = MODE_LOCK;
        else if (r < 50)
        begin
            m = MODE_UNLOCK;
            if (sb.owner_held)
                t = sb.owner_id;
        end
        else if (r < 56)
            m = MODE_UNLOCK;
        else if (r < 70)
        begin
            m = MODE_COND_WAIT;
            if (sb.owner_held)
                t = sb.owner_id;
        end
        else if (r < 86)
            m = MODE_COND_SIGNAL;
        else if (r < 90)
            m = $urandom_range(1) ? MODE_MUTEX_INIT : MODE_COND_INIT;
        else if (r < 94)
            m = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
        else
            m = MODE_COND_WAIT;
    endtask

    initial
    begin
        logic [MODE_W-1:0] m;
        logic [TID_W-1:0]  t;
        int                sent;
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= MODE_MUTEX_INIT;
        thread    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // everything before init
        send_request(MODE_LOCK, 4'd0);
        send_request(MODE_UNLOCK, 4'd15);
        send_request(MODE_COND_WAIT, 4'd3);
        send_request(MODE_COND_SIGNAL, 4'd0);
        send_request(MODE_SPARE_LO, 4'd15);
        send_request(MODE_SPARE_HI, 4'd0);
        // init, re-init, unlock of a free mutex
        send_request(MODE_MUTEX_INIT, 4'd0);
        send_request(MODE_MUTEX_INIT, 4'd15);
        send_request(MODE_UNLOCK, 4'd4);
        send_request(MODE_LOCK, 4'd0);
        // wait before the condition is ready, wait by a non-owner
        send_request(MODE_COND_WAIT, 4'd0);
        send_request(MODE_COND_WAIT, 4'd9);
        send_request(MODE_COND_SIGNAL, 4'd15);
        send_request(MODE_COND_INIT, 4'd15);
        send_request(MODE_COND_INIT, 4'd0);
        send_request(MODE_COND_SIGNAL, 4'd7);
        // relock, queued lockers (twice the same), unlock by a waiter
        send_request(MODE_LOCK, 4'd0);
        send_request(MODE_LOCK, 4'd15);
        send_request(MODE_LOCK, 4'd15);
        send_request(MODE_UNLOCK, 4'd15);
        // wait keeps the mutex, signal wakes, unlocks hand over then free
        send_request(MODE_COND_WAIT, 4'd0);
        send_request(MODE_COND_SIGNAL, 4'd1);
        send_request(MODE_UNLOCK, 4'd0);
        send_request(MODE_UNLOCK, 4'd15);
        send_request(MODE_UNLOCK, 4'd15);
        send_request(MODE_SPARE_HI, 4'd15);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (sent == RANDOM_REQUESTS / 3)
            begin
                send_idle_pct = 78;
                recv_idle_pct <= 16;
            end
            if (sent == 2 * RANDOM_REQUESTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                hold_phase    <= 1'b1;
            end
            pick_request(m, t);
            send_request(m, t);
            if (m != MODE_SPARE_LO && m != MODE_SPARE_HI)
                sent++;
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("PASS queued_mutex_and_condition_unit");
        else
            $display("FAIL queued_mutex_and_condition_unit");
        $finish;
    end

endmodule

/* files.f */
rtl/core/qmcu_pkg.sv
rtl/core/qmcu_ctrl.sv
rtl/core/qmcu_dpath.sv
rtl/core/queued_mutex_and_condition_unit.sv
tb/sv/lock_manager_sb_pkg.sv
tb/sv/tb_top.sv
